[rtl/bbc_pkg.sv]
// ----------------------------------------------------------------------------
// bbc_pkg: shared types and constants for the block buffer cache
// Function codes, status codes, cell interface structs.
// ----------------------------------------------------------------------------
package bbc_pkg;

  localparam int NUM_BUFFERS_DEF = 32;
  localparam int SLOT_W          = 5;
  localparam int DEV_W           = 8;
  localparam int BLK_W           = 32;
  localparam int CNT_W           = 8;
  localparam int STAMP_W         = 32;

  typedef enum logic [1:0] {
    FUNC_GET     = 2'd0,
    FUNC_RELEASE = 2'd1,
    FUNC_PIN     = 2'd2,
    FUNC_UNPIN   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_FREE   = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_RSVD      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_APPLY,
    S_OUT
  } state_t;

  // Search token passed cell to cell: first tag match and oldest free entry.
  typedef struct packed {
    logic               hit;
    logic [6:0]         hit_idx;
    logic               hit_valid;
    logic               free;
    logic [6:0]         free_idx;
    logic [STAMP_W-1:0] free_stamp;
  } scan_t;

  // Update command broadcast to the cells.
  typedef struct packed {
    logic               en;
    logic [6:0]         idx;
    logic               retag;
    logic               inc;
    logic               dec;
    logic               set_one;
    logic               stamp_en;
  } upd_t;

endpackage

[rtl/bbc_cell.sv]
// ----------------------------------------------------------------------------
// bbc_cell: one cache entry
// Holds tag, count, valid and stamp; folds itself into the scan token and
// registers it for the next cell.
// ----------------------------------------------------------------------------
module bbc_cell #(
  parameter int IDX = 0
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [bbc_pkg::DEV_W-1:0]    dev,
  input  logic [bbc_pkg::BLK_W-1:0]    block_number,
  input  logic [bbc_pkg::STAMP_W-1:0]  now,
  input  bbc_pkg::scan_t               scan_in,
  output bbc_pkg::scan_t               scan_out,
  input  bbc_pkg::upd_t                upd,
  output logic [bbc_pkg::CNT_W-1:0]    count
);

  logic [bbc_pkg::DEV_W-1:0]   tag_dev;
  logic [bbc_pkg::BLK_W-1:0]   tag_blk;
  logic                        dvalid;
  logic [bbc_pkg::STAMP_W-1:0] stamp;
  logic                        match;
  logic                        sel;
  bbc_pkg::scan_t              scan_next;

  assign match = (tag_dev == dev) && (tag_blk == block_number);
  assign sel   = upd.en && (upd.idx == 7'(IDX));

  always_comb begin
    scan_next = scan_in;
    if (!scan_in.hit && match) begin
      scan_next.hit       = 1'b1;
      scan_next.hit_idx   = 7'(IDX);
      scan_next.hit_valid = dvalid;
    end
    if (count == '0 && (!scan_in.free || stamp < scan_in.free_stamp)) begin
      scan_next.free       = 1'b1;
      scan_next.free_idx   = 7'(IDX);
      scan_next.free_stamp = stamp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_out <= '0;
    end else begin
      scan_out <= scan_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_dev <= '0;
      tag_blk <= '0;
      dvalid  <= 1'b0;
      stamp   <= '0;
      count   <= '0;
    end else if (sel) begin
      if (upd.retag) begin
        tag_dev <= dev;
        tag_blk <= block_number;
        dvalid  <= 1'b1;
      end
      if (upd.set_one) begin
        count <= 8'd1;
      end else if (upd.inc && count != 8'hFF) begin
        count <= count + 8'd1;
      end else if (upd.dec) begin
        count <= count - 8'd1;
      end
      if (upd.stamp_en) begin
        stamp <= now;
      end
    end
  end

endmodule

[rtl/block_buffer_cache_lru.sv]
// ----------------------------------------------------------------------------
// block_buffer_cache_lru: fully associative buffer cache with refcounts
// Chain of entry cells searched by a registered token, one request at a time.
// ----------------------------------------------------------------------------
// Each request passes through a scan phase and an apply phase: the search
// token moves one cell per cycle down the chain, and the scan ends with the
// capture of the token at the chain's end; the apply state then updates the
// chosen cell and registers the result. A new request is accepted in the
// cycle after the result has been taken.
module block_buffer_cache_lru #(
  parameter int NUM_BUFFERS = bbc_pkg::NUM_BUFFERS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    func,
  input  logic [bbc_pkg::DEV_W-1:0]     dev,
  input  logic [bbc_pkg::BLK_W-1:0]     block_number,
  input  logic [bbc_pkg::SLOT_W-1:0]    slot,
  input  logic [bbc_pkg::STAMP_W-1:0]   now,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bbc_pkg::SLOT_W-1:0]    granted_slot,
  output logic                          hit,
  output logic                          was_valid,
  output logic [1:0]                    status
);

  bbc_pkg::state_t state, state_next;
  bbc_pkg::func_t  r_func;
  logic [bbc_pkg::DEV_W-1:0]   r_dev;
  logic [bbc_pkg::BLK_W-1:0]   r_blk;
  logic [bbc_pkg::SLOT_W-1:0]  r_slot;
  logic [bbc_pkg::STAMP_W-1:0] r_now;
  bbc_pkg::scan_t  chain [NUM_BUFFERS+1];
  bbc_pkg::scan_t  scan_r;
  bbc_pkg::upd_t   upd;
  logic [bbc_pkg::CNT_W-1:0] counts [NUM_BUFFERS];
  logic [bbc_pkg::CNT_W-1:0] slot_cnt;
  logic                      in_range;
  logic [6:0]                scan_cnt;
  logic                      scan_last;

  assign chain[0] = '0;

  for (genvar g = 0; g < NUM_BUFFERS; g++) begin : g_cell
    bbc_cell #(.IDX(g)) u_cell (
      .clk, .rst,
      .dev(r_dev), .block_number(r_blk), .now(r_now),
      .scan_in(chain[g]), .scan_out(chain[g+1]),
      .upd, .count(counts[g])
    );
  end

  assign in_range  = 32'(r_slot) < 32'(NUM_BUFFERS);
  assign slot_cnt  = in_range ? counts[r_slot] : '0;
  assign scan_last = (scan_cnt == 7'(NUM_BUFFERS));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bbc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || state != bbc_pkg::S_SCAN) begin
      scan_cnt <= '0;
    end else begin
      scan_cnt <= scan_cnt + 7'd1;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      bbc_pkg::S_IDLE:  if (in_valid) state_next = bbc_pkg::S_SCAN;
      bbc_pkg::S_SCAN:  if (scan_last) state_next = bbc_pkg::S_APPLY;
      bbc_pkg::S_APPLY: state_next = bbc_pkg::S_OUT;
      bbc_pkg::S_OUT:   if (out_ready) state_next = bbc_pkg::S_IDLE;
      default:          state_next = bbc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state == bbc_pkg::S_IDLE);
    out_valid = (state == bbc_pkg::S_OUT);
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      r_func <= bbc_pkg::func_t'(func);
      r_dev  <= dev;
      r_blk  <= block_number;
      r_slot <= slot;
      r_now  <= now;
    end
    if (state == bbc_pkg::S_SCAN && scan_last) begin
      scan_r <= chain[NUM_BUFFERS];
    end
  end

  // Update command and result, both formed in the apply cycle.
  always_comb begin
    upd = '0;
    if (state == bbc_pkg::S_APPLY) begin
      if (r_func == bbc_pkg::FUNC_GET) begin
        if (scan_r.hit) begin
          upd.en  = 1'b1;
          upd.idx = scan_r.hit_idx;
          upd.inc = 1'b1;
          upd.retag = 1'b1;
        end else if (scan_r.free) begin
          upd.en      = 1'b1;
          upd.idx     = scan_r.free_idx;
          upd.retag   = 1'b1;
          upd.set_one = 1'b1;
        end
      end else if (in_range) begin
        upd.idx = 7'(r_slot);
        if (r_func == bbc_pkg::FUNC_PIN) begin
          upd.en  = 1'b1;
          upd.inc = 1'b1;
        end else if (slot_cnt != '0) begin
          upd.en       = 1'b1;
          upd.dec      = 1'b1;
          upd.stamp_en = (r_func == bbc_pkg::FUNC_RELEASE) && (slot_cnt == 8'd1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == bbc_pkg::S_APPLY) begin
      hit       <= 1'b0;
      was_valid <= 1'b0;
      status    <= bbc_pkg::ST_OK;
      granted_slot <= r_slot;
      if (r_func == bbc_pkg::FUNC_GET) begin
        if (scan_r.hit) begin
          granted_slot <= scan_r.hit_idx[bbc_pkg::SLOT_W-1:0];
          hit          <= 1'b1;
          was_valid    <= scan_r.hit_valid;
        end else if (scan_r.free) begin
          granted_slot <= scan_r.free_idx[bbc_pkg::SLOT_W-1:0];
        end else begin
          granted_slot <= '0;
          status       <= bbc_pkg::ST_NO_FREE;
        end
      end else if (in_range && r_func != bbc_pkg::FUNC_PIN && slot_cnt == '0) begin
        status <= bbc_pkg::ST_UNDERFLOW;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(granted_slot) && $stable(status))
    else $error("result changed while stalled");
  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input and output both open");
  a_hit_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit |-> status == bbc_pkg::ST_OK)
    else $error("hit with error status");
  a_upd_phase: assert property (@(posedge clk) disable iff (rst)
    upd.en |-> state == bbc_pkg::S_APPLY)
    else $error("cell update outside apply");

endmodule

[tb/tb_block_buffer_cache_lru.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_block_buffer_cache_lru: self-checking bench for the block buffer cache
// Directed and random get/release/pin/unpin requests with random idling on
// both sides; a cache predictor computes each expected result in order.
// ----------------------------------------------------------------------------
module tb_block_buffer_cache_lru;

  localparam int NBUF      = bbc_pkg::NUM_BUFFERS_DEF;
  localparam int WDOG_MAX  = 2000;
  localparam int N_RANDOM  = 1400;
  localparam int CALM_TAIL = 150;

  typedef struct packed {
    bbc_pkg::func_t fn;
    logic [7:0]  dv;
    logic [31:0] blk;
    logic [4:0]  sl;
    logic [31:0] tick;
  } req_t;

  typedef struct packed {
    logic [4:0] gslot;
    logic       ghit;
    logic       gvalid;
    bbc_pkg::status_t gstat;
  } resp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] func = '0;
  logic [7:0] dev = '0;
  logic [31:0] block_number = '0;
  logic [4:0] slot = '0;
  logic [31:0] now = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [4:0] granted_slot;
  logic hit;
  logic was_valid;
  logic [1:0] status;

  req_t  pending_reqs[$];
  resp_t expected_resps[$];
  int    errors = 0;
  int    wdog = 0;
  int    in_gap = 0;
  int    out_gap = 0;
  bit    stim_done = 0;
  bit    calm = 0;

  logic [7:0]  c_dev[NBUF];
  logic [31:0] c_blk[NBUF];
  logic [7:0]  c_cnt[NBUF];
  logic        c_val[NBUF];
  logic [31:0] c_stamp[NBUF];

  always #5 clk = ~clk;

  block_buffer_cache_lru u_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .func(func),
    .dev(dev), .block_number(block_number), .slot(slot), .now(now),
    .out_valid(out_valid), .out_ready(out_ready), .granted_slot(granted_slot),
    .hit(hit), .was_valid(was_valid), .status(status)
  );

  function automatic resp_t cache_access(req_t r);
    resp_t o;
    int pick;
    o = '{gslot: r.sl, ghit: 1'b0, gvalid: 1'b0, gstat: bbc_pkg::ST_OK};
    if (r.fn == bbc_pkg::FUNC_GET) begin
      for (int i = 0; i < NBUF; i++) begin
        if (c_dev[i] == r.dv && c_blk[i] == r.blk) begin
          if (c_cnt[i] != 8'hff) c_cnt[i]++;
          o.gslot = 5'(i); o.ghit = 1'b1; o.gvalid = c_val[i];
          c_val[i] = 1'b1;
          return o;
        end
      end
      pick = -1;
      for (int i = 0; i < NBUF; i++)
        if (c_cnt[i] == 0 && (pick < 0 || c_stamp[i] < c_stamp[pick])) pick = i;
      o.gslot = '0;
      if (pick < 0) begin
        o.gstat = bbc_pkg::ST_NO_FREE;
        return o;
      end
      c_dev[pick] = r.dv; c_blk[pick] = r.blk; c_cnt[pick] = 8'd1;
      c_val[pick] = 1'b1;
      o.gslot = 5'(pick);
      return o;
    end
    if (r.sl >= NBUF) return o;
    if (r.fn == bbc_pkg::FUNC_PIN) begin
      if (c_cnt[r.sl] != 8'hff) c_cnt[r.sl]++;
      return o;
    end
    if (c_cnt[r.sl] == 0) begin
      o.gstat = bbc_pkg::ST_UNDERFLOW;
      return o;
    end
    c_cnt[r.sl]--;
    if (r.fn == bbc_pkg::FUNC_RELEASE && c_cnt[r.sl] == 0) c_stamp[r.sl] = r.tick;
    return o;
  endfunction

  task automatic push_req(bbc_pkg::func_t f, logic [7:0] d, logic [31:0] b, logic [4:0] s,
                          logic [31:0] t);
    pending_reqs.push_back('{fn: f, dv: d, blk: b, sl: s, tick: t});
  endtask

  // driver
  always @(posedge clk) begin
    req_t r;
    if (!rst) begin
      if (in_valid && in_ready) begin
        r = pending_reqs.pop_front();
        expected_resps.push_back(cache_access(r));
      end
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          if (!calm && $urandom_range(0, 5) == 0) begin
            in_gap <= $urandom_range(0, 5);
            in_valid <= 1'b0;
          end else begin
            r = pending_reqs[0];
            in_valid <= 1'b1;
            func <= r.fn; dev <= r.dv; block_number <= r.blk;
            slot <= r.sl; now <= r.tick;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    resp_t e;
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) wdog <= 0;
      else wdog <= wdog + 1;
      if (out_valid && out_ready) begin
        if (expected_resps.size() == 0) begin
          $display("%0t: unexpected response slot=%0d", $time, granted_slot);
          errors++;
        end else begin
          e = expected_resps.pop_front();
          if (granted_slot !== e.gslot) begin
            $display("%0t: granted_slot exp %0d got %0d", $time, e.gslot, granted_slot);
            errors++;
          end
          if (hit !== e.ghit) begin
            $display("%0t: hit exp %0d got %0d", $time, e.ghit, hit);
            errors++;
          end
          if (was_valid !== e.gvalid) begin
            $display("%0t: was_valid exp %0d got %0d", $time, e.gvalid, was_valid);
            errors++;
          end
          if (status !== e.gstat) begin
            $display("%0t: status exp %0d got %0d", $time, e.gstat, status);
            errors++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_gap <= $urandom_range(0, 5);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    logic [7:0] d;
    logic [31:0] b;
    logic [31:0] tick;
    int k;
    for (int i = 0; i < NBUF; i++) begin
      c_dev[i] = '0; c_blk[i] = '0; c_cnt[i] = '0; c_val[i] = 1'b0; c_stamp[i] = '0;
    end
    // directed: reset tag hit, extremes, underflow, slot edges
    push_req(bbc_pkg::FUNC_GET, 8'd0, 32'd0, 5'd0, 32'd0);
    push_req(bbc_pkg::FUNC_GET, 8'd0, 32'd0, 5'd0, 32'd0);
    push_req(bbc_pkg::FUNC_GET, 8'hff, 32'hffff_ffff, 5'd31, 32'hffff_ffff);
    push_req(bbc_pkg::FUNC_RELEASE, 8'hff, 32'hffff_ffff, 5'd1, 32'hffff_ffff);
    push_req(bbc_pkg::FUNC_UNPIN, 8'd0, 32'd0, 5'd1, 32'd0);
    push_req(bbc_pkg::FUNC_RELEASE, 8'd0, 32'd0, 5'd31, 32'd5);
    push_req(bbc_pkg::FUNC_PIN, 8'd0, 32'd0, 5'd31, 32'd0);
    push_req(bbc_pkg::FUNC_UNPIN, 8'd0, 32'd0, 5'd31, 32'd0);
    push_req(bbc_pkg::FUNC_RELEASE, 8'd0, 32'd0, 5'd0, 32'd3);
    push_req(bbc_pkg::FUNC_RELEASE, 8'd0, 32'd0, 5'd0, 32'd4);
    push_req(bbc_pkg::FUNC_GET, 8'h5a, 32'h1234_5678, 5'd0, 32'd0);
    push_req(bbc_pkg::FUNC_GET, 8'ha5, 32'h8765_4321, 5'd0, 32'd0);
    pending_reqs.push_back('{fn: bbc_pkg::FUNC_PIN, dv: 8'h00, blk: 32'd0, sl: 5'd2,
                             tick: 32'd0});
    tick = 32'd100;
    k = 0;
    while (k < N_RANDOM) begin
      case ($urandom_range(0, 9))
        0: begin  // pin storm toward saturation or fill the cache
          repeat ($urandom_range(20, 40)) begin
            if ($urandom_range(0, 1))
              push_req(bbc_pkg::FUNC_PIN, 8'($urandom), $urandom,
                       5'($urandom_range(0, 3)), 32'd0);
            else
              push_req(bbc_pkg::FUNC_GET, 8'($urandom), $urandom, 5'($urandom), $urandom);
            k++;
          end
        end
        1: begin  // full random noise
          push_req(bbc_pkg::func_t'($urandom_range(0, 3)), 8'($urandom), $urandom,
                   5'($urandom), $urandom);
          k++;
        end
        default: begin  // get, then release/pin/unpin and a release, with small tag space to make hits likely
          d = 8'($urandom_range(0, 3));
          b = ($urandom_range(0, 3) == 0) ? $urandom : 32'($urandom_range(0, 40));
          tick = tick + $urandom_range(0, 20);
          push_req(bbc_pkg::FUNC_GET, d, b, 5'($urandom), $urandom);
          push_req(bbc_pkg::func_t'($urandom_range(1, 3)), 8'($urandom), $urandom,
                   5'($urandom), ($urandom_range(0, 9) == 0) ? $urandom : tick);
          push_req(bbc_pkg::FUNC_RELEASE, 8'($urandom), $urandom, 5'($urandom), tick);
          k += 3;
        end
      endcase
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    wait (pending_reqs.size() <= CALM_TAIL);
    calm = 1;
    wait (pending_reqs.size() == 0 && expected_resps.size() == 0);
    repeat (20) @(posedge clk);
    stim_done = 1;
  end

  always @(posedge clk) begin
    if (stim_done) begin
      if (errors == 0 && expected_resps.size() == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
    end else if (wdog >= WDOG_MAX) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

endmodule

[filelist.f]
rtl/bbc_pkg.sv
rtl/bbc_cell.sv
rtl/block_buffer_cache_lru.sv
tb/tb_block_buffer_cache_lru.sv
